// File: sv/raa_pkg.sv
// shared types, widths and constants for the rotation angle pipeline
package raa_pkg;

  localparam int IN_W     = 16;
  localparam int ANG_W    = 15;
  localparam int TOL_W    = 12;
  localparam int Q_FRAC   = 12;
  localparam int SQ_IN_W  = 34;
  localparam int SQ_T_W   = SQ_IN_W + 2;
  localparam int ROOT_W   = 17;
  localparam int DKV_W    = 35;
  localparam int RCP_W    = 41;
  localparam int RL_W     = 24;
  localparam int KR_W     = 58;
  localparam int KN_W     = 17;
  localparam int KN_SH    = 26;
  localparam int KN_FRAC  = 14;
  localparam int AU_W     = 18;
  localparam int UP_W     = 18;
  localparam int PR_W     = 36;
  localparam int C_W      = 37;
  localparam int CL_W     = 18;
  localparam int KC_W     = 36;
  localparam int YS_W     = 58;
  localparam int XY_W     = 42;
  localparam int Z_W      = 34;
  localparam int Z_SH     = 18;
  localparam int ANG_MAX  = 12868;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam int SQ_STAGES  = ROOT_W;
  localparam int DIV_STAGES = RCP_W;
  // input reg, products, sums, abs diff, check, 13 post-divide stages, pre-rotation, output
  localparam int LAT_BASE   = 20 + SQ_STAGES + DIV_STAGES;

  typedef struct packed {
    logic [2:0][IN_W-1:0] k;
    logic [2:0][IN_W-1:0] u;
    logic [2:0][IN_W-1:0] v;
  } vecs_t;

  // atan(2^-s) in Q30
  function automatic logic [30:0] atan_q30(input logic [4:0] s);
    logic [30:0] a;
    unique case (s)
      5'd0:  a = 31'd843314857;
      5'd1:  a = 31'd497837829;
      5'd2:  a = 31'd263043836;
      5'd3:  a = 31'd133525159;
      5'd4:  a = 31'd67021687;
      5'd5:  a = 31'd33543516;
      5'd6:  a = 31'd16775851;
      5'd7:  a = 31'd8388437;
      5'd8:  a = 31'd4194283;
      5'd9:  a = 31'd2097149;
      5'd10: a = 31'd1048576;
      5'd11: a = 31'd524288;
      5'd12: a = 31'd262144;
      5'd13: a = 31'd131072;
      5'd14: a = 31'd65536;
      5'd15: a = 31'd32768;
      5'd16: a = 31'd16384;
      5'd17: a = 31'd8192;
      5'd18: a = 31'd4096;
      5'd19: a = 31'd2048;
      5'd20: a = 31'd1024;
      5'd21: a = 31'd512;
      5'd22: a = 31'd256;
      5'd23: a = 31'd128;
      5'd24: a = 31'd64;
      5'd25: a = 31'd32;
      5'd26: a = 31'd16;
      5'd27: a = 31'd8;
      5'd28: a = 31'd4;
      5'd29: a = 31'd2;
      5'd30: a = 31'd1;
      5'd31: a = 31'd0;
    endcase
    return a;
  endfunction

endpackage

// File: sv/rotation_angle_about_axis.sv
// rotation angle about an axis: fully pipelined fixed-point solver
//
// Takes one transaction per clock whenever start is high (busy never rises) and
// returns each result with out_valid, in order; the receiver cannot stall. The
// bit-serial pipelines make up most of its depth: 17 stages of square root, 41
// stages of reciprocal division and one stage per CORDIC step. status 1 means
// no solution and then the angle is 0.
// The tolerance register is written through cfg_valid/cfg_ready (always ready)
// and should only change while no transaction is in flight.
module rotation_angle_about_axis
  import raa_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_axis_x,
  input  logic signed [IN_W-1:0]  in_axis_y,
  input  logic signed [IN_W-1:0]  in_axis_z,
  input  logic signed [IN_W-1:0]  in_from_x,
  input  logic signed [IN_W-1:0]  in_from_y,
  input  logic signed [IN_W-1:0]  in_from_z,
  input  logic signed [IN_W-1:0]  in_to_x,
  input  logic signed [IN_W-1:0]  in_to_y,
  input  logic signed [IN_W-1:0]  in_to_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [TOL_W-1:0]        cfg_tolerance,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_angle,
  output logic                    out_status
);

  localparam int LAT = LAT_BASE + CORDIC_STEPS;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 1);
    return (v + h - $signed({63'd0, v[63]})) >>> s;
  endfunction

  logic [TOL_W-1:0] tol_r;
  logic             vld_r [LAT];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_tolerance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // ---------------- front: squares and dot products ----------------
  vecs_t                    it0_r, it1_r, it2_r;
  logic signed [IN_W:0]     d0 [3];
  logic signed [31:0]       pk_r [3];
  logic signed [33:0]       pd_r [3];
  logic signed [31:0]       pu_r [3];
  logic signed [31:0]       pv_r [3];
  logic signed [31:0]       pku_r [3];
  logic signed [31:0]       pkv_r [3];
  logic [SQ_IN_W-1:0]       n_r [4];
  logic signed [33:0]       ku_r, kv_r;
  logic signed [DKV_W-1:0]  dkuv;
  logic [DKV_W-1:0]         dkv;

  always_ff @(posedge clk) begin
    it0_r.k <= {in_axis_z, in_axis_y, in_axis_x};
    it0_r.u <= {in_from_z, in_from_y, in_from_x};
    it0_r.v <= {in_to_z, in_to_y, in_to_x};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0[i] = $signed({it0_r.u[i][IN_W-1], it0_r.u[i]})
            - $signed({it0_r.k[i][IN_W-1], it0_r.k[i]});
    end
  end

  always_ff @(posedge clk) begin
    it1_r <= it0_r;
    for (int i = 0; i < 3; i++) begin
      pk_r[i]  <= $signed(it0_r.k[i]) * $signed(it0_r.k[i]);
      pd_r[i]  <= d0[i] * d0[i];
      pu_r[i]  <= $signed(it0_r.u[i]) * $signed(it0_r.u[i]);
      pv_r[i]  <= $signed(it0_r.v[i]) * $signed(it0_r.v[i]);
      pku_r[i] <= $signed(it0_r.k[i]) * $signed(it0_r.u[i]);
      pkv_r[i] <= $signed(it0_r.k[i]) * $signed(it0_r.v[i]);
    end
  end

  always_ff @(posedge clk) begin
    it2_r  <= it1_r;
    n_r[0] <= SQ_IN_W'($unsigned(pk_r[0])) + SQ_IN_W'($unsigned(pk_r[1]))
            + SQ_IN_W'($unsigned(pk_r[2]));
    n_r[1] <= $unsigned(pd_r[0]) + $unsigned(pd_r[1]) + $unsigned(pd_r[2]);
    n_r[2] <= SQ_IN_W'($unsigned(pu_r[0])) + SQ_IN_W'($unsigned(pu_r[1]))
            + SQ_IN_W'($unsigned(pu_r[2]));
    n_r[3] <= SQ_IN_W'($unsigned(pv_r[0])) + SQ_IN_W'($unsigned(pv_r[1]))
            + SQ_IN_W'($unsigned(pv_r[2]));
    ku_r   <= 34'(pku_r[0]) + 34'(pku_r[1]) + 34'(pku_r[2]);
    kv_r   <= 34'(pkv_r[0]) + 34'(pkv_r[1]) + 34'(pkv_r[2]);
  end

  assign dkuv = DKV_W'(ku_r) - DKV_W'(kv_r);
  assign dkv  = dkuv[DKV_W-1] ? $unsigned(-dkuv) : $unsigned(dkuv);

  // ---------------- four square roots, one bit per stage ----------------
  // lanes: 0 |k|, 1 |u-k|, 2 |u|, 3 |v|
  logic [SQ_IN_W-1:0] sq_rem_r  [SQ_STAGES+1][4];
  logic [ROOT_W-1:0]  sq_root_r [SQ_STAGES+1][4];
  vecs_t              sq_it_r   [SQ_STAGES+1];
  logic [DKV_W-1:0]   sq_dkv_r  [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    sq_it_r[0]  <= it2_r;
    sq_dkv_r[0] <= dkv;
    for (int l = 0; l < 4; l++) begin
      sq_rem_r[0][l]  <= n_r[l];
      sq_root_r[0][l] <= '0;
    end
  end

  for (genvar j = 1; j <= SQ_STAGES; j++) begin : g_sqrt
    localparam int B = ROOT_W - j;
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [SQ_T_W-1:0] trial;
      logic              hit;
      // (2*root + 2^B) * 2^B, root has no bits below B yet
      assign trial = (SQ_T_W'(sq_root_r[j-1][l]) << (B + 1)) | (SQ_T_W'(1) << (2 * B));
      assign hit   = SQ_T_W'(sq_rem_r[j-1][l]) >= trial;
      always_ff @(posedge clk) begin
        if (hit) begin
          sq_rem_r[j][l]  <= sq_rem_r[j-1][l] - SQ_IN_W'(trial);
          sq_root_r[j][l] <= sq_root_r[j-1][l] | (ROOT_W'(1) << B);
        end else begin
          sq_rem_r[j][l]  <= sq_rem_r[j-1][l];
          sq_root_r[j][l] <= sq_root_r[j-1][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      sq_it_r[j]  <= sq_it_r[j-1];
      sq_dkv_r[j] <= sq_dkv_r[j-1];
    end
  end

  // ---------------- solvability check ----------------
  logic [ROOT_W-1:0] nk, nuk, nu, nv, nud;
  logic              fail;

  assign nk  = sq_root_r[SQ_STAGES][0];
  assign nuk = sq_root_r[SQ_STAGES][1];
  assign nu  = sq_root_r[SQ_STAGES][2];
  assign nv  = sq_root_r[SQ_STAGES][3];
  assign nud = (nu >= nv) ? nu - nv : nv - nu;
  assign fail = (nk == '0) || (nk < ROOT_W'(tol_r)) || (nuk < ROOT_W'(tol_r))
             || (nud > ROOT_W'(tol_r))
             || (sq_dkv_r[SQ_STAGES] > (DKV_W'(tol_r) << Q_FRAC));

  // ---------------- reciprocal 2^40 / |k|, one quotient bit per stage ----------------
  logic [ROOT_W-1:0] dv_rem_r  [DIV_STAGES+1];
  logic [ROOT_W-1:0] dv_d_r    [DIV_STAGES+1];
  logic [RCP_W-1:0]  dv_q_r    [DIV_STAGES+1];
  vecs_t             dv_it_r   [DIV_STAGES+1];
  logic              dv_fail_r [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    dv_rem_r[0]  <= '0;
    dv_d_r[0]    <= nk;
    dv_q_r[0]    <= '0;
    dv_it_r[0]   <= sq_it_r[SQ_STAGES];
    dv_fail_r[0] <= fail;
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    // the dividend has a single set bit at the top
    localparam logic IN_BIT = (j == 1);
    logic [ROOT_W:0] rem2;
    logic            ge;
    assign rem2 = {dv_rem_r[j-1], IN_BIT};
    assign ge   = rem2 >= {1'b0, dv_d_r[j-1]};
    always_ff @(posedge clk) begin
      dv_rem_r[j]  <= ge ? ROOT_W'(rem2 - {1'b0, dv_d_r[j-1]}) : ROOT_W'(rem2);
      dv_q_r[j]    <= {dv_q_r[j-1][RCP_W-2:0], ge};
      dv_d_r[j]    <= dv_d_r[j-1];
      dv_it_r[j]   <= dv_it_r[j-1];
      dv_fail_r[j] <= dv_fail_r[j-1];
    end
  end

  // ---------------- unit axis and projections ----------------
  logic [RCP_W-1:0]         rcp;
  logic signed [40:0]       p1_lo_r [3];
  logic signed [33:0]       p1_hi_r [3];
  logic signed [KR_W-1:0]   p2_kr_r [3];
  logic signed [KN_W-1:0]   p3_kn_r [3], p4_kn_r [3], p5_kn_r [3], p6_kn_r [3], p7_kn_r [3];
  logic signed [KN_W-1:0]   p8_kn_r [3], p9_kn_r [3];
  logic signed [32:0]       p4_ku_r [3], p4_kv_r [3];
  logic signed [AU_W-1:0]   p5_au_r, p5_av_r;
  logic signed [34:0]       p6_qa_r [3], p6_qb_r [3];
  logic signed [UP_W-1:0]   p7_up_r [3], p7_vp_r [3];
  logic signed [PR_W-1:0]   p8_m_r [6], p8_d_r [3];
  logic signed [C_W-1:0]    p9_c_r [3];
  logic signed [KC_W-1:0]   p10_ch_r [3], p10_cl_r [3];
  logic signed [YS_W-1:0]   p11_t_r [3];
  logic signed [YS_W-1:0]   p12_ys_r;
  logic signed [XY_W-1:0]   p9_x_r, p10_x_r, p11_x_r, p12_x_r, p13_x_r, p13_y_r;
  vecs_t                    p1_it_r, p2_it_r, p3_it_r, p4_it_r, p5_it_r, p6_it_r;
  logic                     p1_fail_r, p2_fail_r, p3_fail_r, p4_fail_r, p5_fail_r, p6_fail_r;
  logic                     p7_fail_r, p8_fail_r, p9_fail_r, p10_fail_r, p11_fail_r;
  logic                     p12_fail_r, p13_fail_r;

  assign rcp = dv_q_r[DIV_STAGES];

  always_ff @(posedge clk) begin
    // k * recip split in two partial products
    for (int i = 0; i < 3; i++) begin
      p1_lo_r[i] <= $signed(dv_it_r[DIV_STAGES].k[i]) * $signed({1'b0, rcp[RL_W-1:0]});
      p1_hi_r[i] <= $signed(dv_it_r[DIV_STAGES].k[i]) * $signed({1'b0, rcp[RCP_W-1:RL_W]});
    end
    p1_it_r   <= dv_it_r[DIV_STAGES];
    p1_fail_r <= dv_fail_r[DIV_STAGES];

    for (int i = 0; i < 3; i++) begin
      p2_kr_r[i] <= (KR_W'(p1_hi_r[i]) <<< RL_W) + KR_W'(p1_lo_r[i]);
    end
    p2_it_r   <= p1_it_r;
    p2_fail_r <= p1_fail_r;

    for (int i = 0; i < 3; i++) begin
      p3_kn_r[i] <= KN_W'(rnd_sh(64'(p2_kr_r[i]), KN_SH));
    end
    p3_it_r   <= p2_it_r;
    p3_fail_r <= p2_fail_r;

    for (int i = 0; i < 3; i++) begin
      p4_ku_r[i] <= p3_kn_r[i] * $signed(p3_it_r.u[i]);
      p4_kv_r[i] <= p3_kn_r[i] * $signed(p3_it_r.v[i]);
    end
    p4_kn_r   <= p3_kn_r;
    p4_it_r   <= p3_it_r;
    p4_fail_r <= p3_fail_r;

    p5_au_r   <= AU_W'(rnd_sh(64'(p4_ku_r[0]) + 64'(p4_ku_r[1]) + 64'(p4_ku_r[2]), KN_FRAC));
    p5_av_r   <= AU_W'(rnd_sh(64'(p4_kv_r[0]) + 64'(p4_kv_r[1]) + 64'(p4_kv_r[2]), KN_FRAC));
    p5_kn_r   <= p4_kn_r;
    p5_it_r   <= p4_it_r;
    p5_fail_r <= p4_fail_r;

    for (int i = 0; i < 3; i++) begin
      p6_qa_r[i] <= p5_au_r * p5_kn_r[i];
      p6_qb_r[i] <= p5_av_r * p5_kn_r[i];
    end
    p6_kn_r   <= p5_kn_r;
    p6_it_r   <= p5_it_r;
    p6_fail_r <= p5_fail_r;

    for (int i = 0; i < 3; i++) begin
      p7_up_r[i] <= UP_W'($signed(p6_it_r.u[i])) - UP_W'(rnd_sh(64'(p6_qa_r[i]), KN_FRAC));
      p7_vp_r[i] <= UP_W'($signed(p6_it_r.v[i])) - UP_W'(rnd_sh(64'(p6_qb_r[i]), KN_FRAC));
    end
    p7_kn_r   <= p6_kn_r;
    p7_fail_r <= p6_fail_r;

    // cross product terms and dot product terms
    p8_m_r[0] <= p7_up_r[1] * p7_vp_r[2];
    p8_m_r[1] <= p7_up_r[2] * p7_vp_r[1];
    p8_m_r[2] <= p7_up_r[2] * p7_vp_r[0];
    p8_m_r[3] <= p7_up_r[0] * p7_vp_r[2];
    p8_m_r[4] <= p7_up_r[0] * p7_vp_r[1];
    p8_m_r[5] <= p7_up_r[1] * p7_vp_r[0];
    for (int i = 0; i < 3; i++) begin
      p8_d_r[i] <= p7_up_r[i] * p7_vp_r[i];
    end
    p8_kn_r   <= p7_kn_r;
    p8_fail_r <= p7_fail_r;

    for (int i = 0; i < 3; i++) begin
      p9_c_r[i] <= C_W'(p8_m_r[2*i]) - C_W'(p8_m_r[2*i+1]);
    end
    p9_x_r    <= XY_W'(p8_d_r[0]) + XY_W'(p8_d_r[1]) + XY_W'(p8_d_r[2]);
    p9_kn_r   <= p8_kn_r;
    p9_fail_r <= p8_fail_r;

    // kn . c with c split into high and low halves
    for (int i = 0; i < 3; i++) begin
      p10_ch_r[i] <= p9_kn_r[i] * $signed(p9_c_r[i][C_W-1:CL_W]);
      p10_cl_r[i] <= p9_kn_r[i] * $signed({1'b0, p9_c_r[i][CL_W-1:0]});
    end
    p10_x_r    <= p9_x_r;
    p10_fail_r <= p9_fail_r;

    for (int i = 0; i < 3; i++) begin
      p11_t_r[i] <= (YS_W'(p10_ch_r[i]) <<< CL_W) + YS_W'(p10_cl_r[i]);
    end
    p11_x_r    <= p10_x_r;
    p11_fail_r <= p10_fail_r;

    p12_ys_r   <= p11_t_r[0] + p11_t_r[1] + p11_t_r[2];
    p12_x_r    <= p11_x_r;
    p12_fail_r <= p11_fail_r;

    p13_y_r    <= XY_W'(rnd_sh(64'(p12_ys_r), KN_FRAC));
    p13_x_r    <= p12_x_r;
    p13_fail_r <= p12_fail_r;
  end

  // ---------------- vectoring cordic ----------------
  logic signed [XY_W-1:0] cx_r [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz_r [CORDIC_STEPS+1];
  logic                   c_zero_r [CORDIC_STEPS+1];
  logic                   c_fail_r [CORDIC_STEPS+1];

  // fold the left half-plane into the right
  always_ff @(posedge clk) begin
    c_zero_r[0] <= (p13_x_r == '0) && (p13_y_r == '0);
    c_fail_r[0] <= p13_fail_r;
    if (p13_x_r[XY_W-1] && !p13_y_r[XY_W-1]) begin
      cx_r[0] <= p13_y_r;
      cy_r[0] <= -p13_x_r;
      cz_r[0] <= HALF_PI_Q30;
    end else if (p13_x_r[XY_W-1]) begin
      cx_r[0] <= -p13_y_r;
      cy_r[0] <= p13_x_r;
      cz_r[0] <= -HALF_PI_Q30;
    end else begin
      cx_r[0] <= p13_x_r;
      cy_r[0] <= p13_y_r;
      cz_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_cordic
    localparam int SH = j - 1;
    logic                   pos;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;
    assign pos = !cy_r[j-1][XY_W-1] && (cy_r[j-1] != '0);
    assign xs  = cx_r[j-1] >>> SH;
    assign ys  = cy_r[j-1] >>> SH;
    assign at  = $signed(Z_W'(atan_q30(5'(SH))));
    always_ff @(posedge clk) begin
      if (pos) begin
        cx_r[j] <= cx_r[j-1] + ys;
        cy_r[j] <= cy_r[j-1] - xs;
        cz_r[j] <= cz_r[j-1] + at;
      end else begin
        cx_r[j] <= cx_r[j-1] - ys;
        cy_r[j] <= cy_r[j-1] + xs;
        cz_r[j] <= cz_r[j-1] - at;
      end
      c_zero_r[j] <= c_zero_r[j-1];
      c_fail_r[j] <= c_fail_r[j-1];
    end
  end

  // ---------------- output ----------------
  logic signed [63:0]      zr;
  logic signed [ANG_W-1:0] zc;
  logic signed [ANG_W-1:0] out_angle_r;
  logic                    out_status_r;

  assign zr = rnd_sh(64'(cz_r[CORDIC_STEPS]), Z_SH);

  always_comb begin
    priority if (zr > 64'(ANG_MAX)) begin
      zc = ANG_W'(ANG_MAX);
    end else if (zr < -64'(ANG_MAX)) begin
      zc = -ANG_W'(ANG_MAX);
    end else begin
      zc = ANG_W'(zr);
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r  <= (c_fail_r[CORDIC_STEPS] || c_zero_r[CORDIC_STEPS]) ? '0 : zc;
    out_status_r <= c_fail_r[CORDIC_STEPS];
  end

  assign out_valid  = vld_r[LAT-1];
  assign out_angle  = out_angle_r;
  assign out_status = out_status_r;

endmodule

// File: sv/raa_checker.sv
// port-level checks for the rotation angle pipeline, bound to the top level
module raa_checker
  import raa_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic signed [ANG_W-1:0] out_angle,
  input logic                    out_status
);

  localparam int LAT = LAT_BASE + CORDIC_STEPS;

  // a result only appears a fixed latency after an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_no_sol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_angle == '0)
    else $error("no-solution result carries a nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle <= ANG_W'(ANG_MAX)) && (out_angle >= -ANG_W'(ANG_MAX)))
    else $error("angle outside +-pi");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("pipeline refused a transaction");

endmodule

bind rotation_angle_about_axis raa_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_raa_checker (.*);
